// ===== hdl/sacl_pkg.sv =====
// shared types and constants for the set-associative lru cache model
// no dependencies; imported by set_assoc_cache_lru_sim and the testbench
package sacl_pkg;

  localparam int DEF_MAX_SET_BITS = 8;
  localparam int DEF_MAX_WAYS     = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_BLOCK_BITS = 2'd1,
    CFG_WAYS       = 2'd2
  } cfg_reg_t;

  localparam logic [3:0] SET_BITS_RST   = 4'd4;
  localparam logic [4:0] BLOCK_BITS_RST = 5'd4;
  localparam logic [3:0] WAYS_RST       = 4'd1;

  // one cache line as held in the set memory
  typedef struct packed {
    logic        valid;
    logic [31:0] tag;
    logic [31:0] stamp;
  } line_t;

endpackage

// ===== hdl/set_assoc_cache_lru_sim.sv =====
// set-associative cache model with lru replacement and hit/miss/eviction totals
// depends on sacl_pkg
//
// Each transaction on the input channel carries a byte address and a mode; mode 0 gives one
// result, mode 1 (modify) accesses the same address twice and gives two results, the second
// with last set. All lines of a set sit in one row of a single-port-style memory with a
// registered read: the row is read as the transaction is taken, then tags and stamps are
// compared in parallel and, once the output register is free, the updated row is written
// back while the result is loaded into the output register. The second access of a modify
// reuses the row just written. After reset the memory is swept clear, one set per cycle,
// through all 2**MAX_SET_BITS sets (256 by default) before the first transaction is taken;
// configuration writes are taken at any time but must only be made while the block is idle.
module set_assoc_cache_lru_sim #(
  parameter int MAX_SET_BITS = sacl_pkg::DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = sacl_pkg::DEF_MAX_WAYS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           mode,
  input  logic [31:0]                    address,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           hit,
  output logic                           evicted,
  output logic [31:0]                    hit_total,
  output logic [31:0]                    miss_total,
  output logic [31:0]                    evict_total,
  output logic                           last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sacl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sacl_pkg::*;

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int IDX_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int LIM_W    = $clog2(MAX_WAYS + 1);

  typedef line_t [MAX_WAYS-1:0] row_t;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_LOOK  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [3:0] set_bits;
  logic [4:0] block_bits;
  logic [3:0] ways_in_use;

  logic [IDX_W-1:0] clr_cnt;
  logic             second_pend;
  logic             fwd;
  logic [IDX_W-1:0] idx_q;
  logic [31:0]      tag_q;
  row_t             row_fwd;
  logic [31:0]      access_clock;

  row_t mem [NUM_SETS];
  row_t rdata;
  logic             rd_en;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  row_t             wr_row;

  // address split on the incoming transaction
  logic [3:0]       sb;
  logic [5:0]       sum_bits;
  logic [31:0]      shifted;
  logic [31:0]      idx_mask;
  logic [IDX_W-1:0] idx_in;
  logic [31:0]      tag_in;

  // lookup on the row
  row_t                 row_cur;
  row_t                 row_new;
  logic [4:0]           ways_ext;
  logic [LIM_W-1:0]     lim;
  logic [MAX_WAYS-1:0]  in_use;
  logic [MAX_WAYS-1:0]  match;
  logic [MAX_WAYS-1:0]  free;
  logic [MAX_WAYS-1:0]  oldest;
  logic                 hit_any;
  logic                 free_any;
  logic [WAY_W-1:0]     hit_way;
  logic [WAY_W-1:0]     free_way;
  logic [WAY_W-1:0]     old_way;
  logic [WAY_W-1:0]     victim;
  logic [31:0]          stamp_new;
  logic                 go;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign go        = (state == S_LOOK) && (!out_valid || out_ready);

  always_comb begin
    sb       = (set_bits > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : set_bits;
    sum_bits = {1'b0, block_bits} + {2'b00, sb};
    shifted  = address >> block_bits;
    idx_mask = ~(32'hFFFF_FFFF << sb);
    idx_in   = IDX_W'(shifted & idx_mask);
    tag_in   = (sum_bits >= 6'd32) ? 32'd0 : (address >> sum_bits);
  end

  always_comb begin
    ways_ext = {1'b0, ways_in_use};
    if (ways_ext == 5'd0) begin
      ways_ext = 5'd1;
    end
    if (ways_ext > 5'(MAX_WAYS)) begin
      ways_ext = 5'(MAX_WAYS);
    end
    lim = LIM_W'(ways_ext);
  end

  assign row_cur   = fwd ? row_fwd : rdata;
  assign stamp_new = access_clock + 32'd1;

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w] = LIM_W'(w) < lim;
      match[w]  = in_use[w] && row_cur[w].valid && (row_cur[w].tag == tag_q);
      free[w]   = in_use[w] && !row_cur[w].valid;
    end
    // way i is the lru victim if it is strictly older than every lower way
    // and no newer than every higher way
    for (int i = 0; i < MAX_WAYS; i++) begin
      oldest[i] = in_use[i];
      for (int j = 0; j < MAX_WAYS; j++) begin
        if (in_use[j] && (j < i) && !(row_cur[i].stamp < row_cur[j].stamp)) begin
          oldest[i] = 1'b0;
        end
        if (in_use[j] && (j > i) && (row_cur[i].stamp > row_cur[j].stamp)) begin
          oldest[i] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    hit_way  = '0;
    free_way = '0;
    old_way  = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WAY_W'(w);
      end
      if (free[w]) begin
        free_way = WAY_W'(w);
      end
      if (oldest[w]) begin
        old_way = WAY_W'(w);
      end
    end
    hit_any  = |match;
    free_any = |free;
    priority if (hit_any) begin
      victim = hit_way;
    end else if (free_any) begin
      victim = free_way;
    end else begin
      victim = old_way;
    end
    row_new = row_cur;
    row_new[victim] = '{valid: 1'b1, tag: tag_q, stamp: stamp_new};
  end

  always_comb begin
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    wr_addr = idx_q;
    wr_row  = row_new;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt;
        wr_row  = '0;
        if (clr_cnt == IDX_W'(NUM_SETS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          rd_en      = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        if (go) begin
          wr_en = 1'b1;
          if (!second_pend) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rdata <= mem[idx_in];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_cnt      <= '0;
      set_bits     <= SET_BITS_RST;
      block_bits   <= BLOCK_BITS_RST;
      ways_in_use  <= WAYS_RST;
      second_pend  <= 1'b0;
      fwd          <= 1'b0;
      access_clock <= '0;
      hit_total    <= '0;
      miss_total   <= '0;
      evict_total  <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + IDX_W'(1);
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_SET_BITS:   set_bits    <= cfg_data[3:0];
          CFG_BLOCK_BITS: block_bits  <= cfg_data;
          CFG_WAYS:       ways_in_use <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_valid && in_ready) begin
        second_pend <= mode;
        fwd         <= 1'b0;
      end
      if (go) begin
        out_valid    <= 1'b1;
        access_clock <= stamp_new;
        second_pend  <= 1'b0;
        fwd          <= 1'b1;
        if (hit_any) begin
          hit_total <= hit_total + 32'd1;
        end else begin
          miss_total <= miss_total + 32'd1;
          if (!free_any) begin
            evict_total <= evict_total + 32'd1;
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      idx_q <= idx_in;
      tag_q <= tag_in;
    end
    if (go) begin
      row_fwd <= row_new;
      hit     <= hit_any;
      evicted <= !hit_any && !free_any;
      last    <= !second_pend;
    end
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// self-checking testbench for set_assoc_cache_lru_sim: directed and random address traffic
// checked against an in-bench lru cache predictor; depends on sacl_pkg and the dut only
module testbench;
  import sacl_pkg::*;

  localparam int MAX_SB    = DEF_MAX_SET_BITS;
  localparam int MAX_W     = DEF_MAX_WAYS;
  localparam int NUM_LINES = (1 << MAX_SB) * MAX_W;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;  // index with no register behind it
  localparam bit MODE_SINGLE = 1'b0;
  localparam bit MODE_MODIFY = 1'b1;

  typedef struct packed {
    bit        hit;
    bit        evicted;
    bit [31:0] hit_total;
    bit [31:0] miss_total;
    bit [31:0] evict_total;
    bit        last;
  } lookup_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  mode = 1'b0;
  logic [31:0]           address = 32'd0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  hit;
  logic                  evicted;
  logic [31:0]           hit_total;
  logic [31:0]           miss_total;
  logic [31:0]           evict_total;
  logic                  last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_SET_BITS;
  logic [CFG_DATA_W-1:0] cfg_data = 5'd0;

  // predictor state
  bit        line_ok[NUM_LINES];
  bit [31:0] line_key[NUM_LINES];
  bit [31:0] line_age[NUM_LINES];
  bit [31:0] tick;
  bit [31:0] hits_so_far, misses_so_far, evicts_so_far;
  bit [3:0]  cur_set_bits   = SET_BITS_RST;
  bit [4:0]  cur_block_bits = BLOCK_BITS_RST;
  bit [3:0]  cur_ways       = WAYS_RST;

  lookup_t   lookups_due[$];
  bit [31:0] hot_addr[$];
  bit        stalls_on = 1'b1;
  int        ready_hold = 0;
  int        n_fail = 0;
  int        n_items = 0;
  int        n_results = 0;
  int        n_hits_seen = 0;
  int        n_evicts_seen = 0;
  int        n_geometries = 0;

  set_assoc_cache_lru_sim dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .mode(mode), .address(address),
    .out_valid(out_valid), .out_ready(out_ready),
    .hit(hit), .evicted(evicted), .hit_total(hit_total), .miss_total(miss_total),
    .evict_total(evict_total), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("set_assoc_cache_lru_sim regression: fail");
    $finish;
  end

  // one access of the cache, pushes the result it should give
  task automatic cache_lookup(input bit [31:0] addr, input bit fin);
    int        sb, bb, ways, base, victim;
    bit [31:0] idx, key, oldest;
    bit        found_hit, found_free, ev;
    lookup_t   r;
    sb = (cur_set_bits > MAX_SB) ? MAX_SB : int'(cur_set_bits);
    bb = int'(cur_block_bits);
    ways = (cur_ways == 0) ? 1 : ((cur_ways > MAX_W) ? MAX_W : int'(cur_ways));
    idx = (addr >> bb) & ((32'd1 << sb) - 32'd1);
    key = (bb + sb >= 32) ? 32'd0 : (addr >> (bb + sb));
    base = int'(idx) * MAX_W;
    tick = tick + 32'd1;
    found_hit = 1'b0;
    found_free = 1'b0;
    ev = 1'b0;
    victim = 0;
    for (int w = 0; w < ways; w++) begin
      if (!found_hit && line_ok[base + w] && line_key[base + w] == key) begin
        line_age[base + w] = tick;
        found_hit = 1'b1;
      end
    end
    if (found_hit) begin
      hits_so_far = hits_so_far + 32'd1;
    end else begin
      misses_so_far = misses_so_far + 32'd1;
      for (int w = 0; w < ways; w++) begin
        if (!found_free && !line_ok[base + w]) begin
          victim = w;
          found_free = 1'b1;
        end
      end
      if (!found_free) begin
        oldest = line_age[base];
        for (int w = 1; w < ways; w++) begin
          if (line_age[base + w] < oldest) begin
            oldest = line_age[base + w];
            victim = w;
          end
        end
        ev = 1'b1;
        evicts_so_far = evicts_so_far + 32'd1;
      end
      line_ok[base + victim]  = 1'b1;
      line_key[base + victim] = key;
      line_age[base + victim] = tick;
    end
    r.hit = found_hit;
    r.evicted = ev;
    r.hit_total = hits_so_far;
    r.miss_total = misses_so_far;
    r.evict_total = evicts_so_far;
    r.last = fin;
    lookups_due.push_back(r);
  endtask

  // valid stays high across back-to-back transactions; end_stream drops it
  task automatic send_access(input bit m, input bit [31:0] a);
    if (stalls_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    if (m == MODE_MODIFY) begin
      cache_lookup(a, 1'b0);
      cache_lookup(a, 1'b1);
    end else begin
      cache_lookup(a, 1'b1);
    end
    in_valid <= 1'b1;
    mode <= m;
    address <= a;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_items++;
  endtask

  task automatic end_stream();
    in_valid <= 1'b0;
  endtask

  task automatic program_cache(input bit [3:0] sb, input bit [4:0] bb, input bit [3:0] ways,
                               input bit poke_spare);
    logic [CFG_IDX_W-1:0]  idx_list[4];
    logic [CFG_DATA_W-1:0] data_list[4];
    int n;
    idx_list[0] = CFG_SET_BITS;   data_list[0] = {1'($urandom), sb};
    idx_list[1] = CFG_BLOCK_BITS; data_list[1] = bb;
    idx_list[2] = CFG_WAYS;       data_list[2] = {1'($urandom), ways};
    idx_list[3] = CFG_NONE;       data_list[3] = 5'($urandom);
    n = poke_spare ? 4 : 3;
    while (lookups_due.size() != 0) @(posedge clk);
    for (int i = 0; i < n; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_list[i];
      cfg_data <= data_list[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    cur_set_bits = sb;
    cur_block_bits = bb;
    cur_ways = ways;
    n_geometries++;
  endtask

  task automatic check_field(input string name, input bit [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got);
      n_fail++;
    end
  endtask

  // result stall bursts
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_ready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      ready_hold <= $urandom_range(1, 19) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    lookup_t want;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (hit === 1'b1) n_hits_seen++;
      if (evicted === 1'b1) n_evicts_seen++;
      if (lookups_due.size() == 0) begin
        $error("result transaction with nothing outstanding");
        n_fail++;
      end else begin
        want = lookups_due.pop_front();
        check_field("hit", 32'(want.hit), 32'(hit));
        check_field("evicted", 32'(want.evicted), 32'(evicted));
        check_field("hit_total", want.hit_total, hit_total);
        check_field("miss_total", want.miss_total, miss_total);
        check_field("evict_total", want.evict_total, evict_total);
        check_field("last", 32'(want.last), 32'(last));
      end
    end
  end

  task automatic test_default_geometry();
    // 16 sets, 16-byte lines, direct mapped
    send_access(MODE_SINGLE, 32'h0000_0000);
    send_access(MODE_SINGLE, 32'h0000_000F);
    send_access(MODE_MODIFY, 32'hFFFF_FFFF);
    send_access(MODE_SINGLE, 32'h0000_0100);
    send_access(MODE_SINGLE, 32'h0000_0000);
    end_stream();
  endtask

  task automatic test_lru_order();
    // one set, four ways, spare register index poked too
    program_cache(4'd0, 5'd0, 4'd4, 1'b1);
    send_access(MODE_SINGLE, 32'h0000_0010);
    send_access(MODE_SINGLE, 32'h0000_0020);
    send_access(MODE_SINGLE, 32'h0000_0030);
    send_access(MODE_SINGLE, 32'h0000_0040);
    send_access(MODE_SINGLE, 32'h0000_0010);
    send_access(MODE_SINGLE, 32'h0000_0050);
    send_access(MODE_MODIFY, 32'h0000_0020);
    send_access(MODE_SINGLE, 32'h0000_0010);
    end_stream();
  endtask

  task automatic test_wide_fields();
    // set bits saturate, zero ways acts as one, offset plus index covers the whole address
    program_cache(4'd15, 5'd31, 4'd0, 1'b0);
    send_access(MODE_SINGLE, 32'h8000_0000);
    send_access(MODE_SINGLE, 32'h7FFF_FFFF);
    send_access(MODE_SINGLE, 32'hFFFF_FFFF);
    end_stream();
    // ways saturate to the maximum
    program_cache(4'd8, 5'd24, 4'd15, 1'b0);
    send_access(MODE_MODIFY, 32'hAB00_0000);
    send_access(MODE_SINGLE, 32'hAB12_3456);
    end_stream();
    // back to reset geometry, with lines stored earlier still in the memory
    program_cache(SET_BITS_RST, BLOCK_BITS_RST, WAYS_RST, 1'b0);
    send_access(MODE_SINGLE, 32'h0000_0100);
    end_stream();
  endtask

  task automatic run_traffic(input int count, input bit [3:0] sb, input bit [4:0] bb,
                             input bit [3:0] ways);
    bit [31:0] a, off_mask;
    int        pool_max;
    program_cache(sb, bb, ways, $urandom_range(0, 3) == 0);
    off_mask = (32'd1 << bb) - 32'd1;
    pool_max = $urandom_range(3, 24);
    for (int i = 0; i < count; i++) begin
      if (hot_addr.size() == 0 || $urandom_range(0, 99) < 25) begin
        a = $urandom;
        if (hot_addr.size() < pool_max) hot_addr.push_back(a);
        else hot_addr[$urandom_range(0, hot_addr.size() - 1)] = a;
      end else begin
        a = hot_addr[$urandom_range(0, hot_addr.size() - 1)] ^ ($urandom & off_mask);
      end
      send_access(($urandom_range(0, 9) < 3) ? MODE_MODIFY : MODE_SINGLE, a);
    end
    end_stream();
  endtask

  task automatic test_random_traffic();
    run_traffic(110, 4'd15, 5'd31, 4'd15);
    run_traffic(110, 4'd0, 5'd0, 4'd0);
    for (int p = 0; p < 6; p++) begin
      run_traffic(105,
                  ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 2)) : 4'($urandom_range(0, 15)),
                  5'($urandom_range(0, 31)),
                  4'($urandom_range(0, 15)));
    end
    // last stretch runs at full rate on both sides
    stalls_on = 1'b0;
    run_traffic(100, 4'($urandom_range(0, 3)), 5'($urandom_range(0, 8)), 4'($urandom_range(1, 8)));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_default_geometry();
    test_lru_order();
    test_wide_fields();
    test_random_traffic();
    while (lookups_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("ran %0d address transactions, %0d lookups checked (%0d hits, %0d evictions)",
             n_items, n_results, n_hits_seen, n_evicts_seen);
    $display("across %0d cache geometries, including saturated and zero-way settings",
             n_geometries + 1);
    if (n_fail == 0) begin
      $display("set_assoc_cache_lru_sim regression: pass");
    end else begin
      $display("set_assoc_cache_lru_sim regression: fail");
    end
    $finish;
  end

endmodule
